// File: src/ipl_pkg.sv
// ----------------------------------------------------------------------------
// Impedance packet line parser package
// Shared phase codes, field targets, byte codes and character helpers.
// ----------------------------------------------------------------------------
package ipl_pkg;

    // Parser phase within one line
    typedef enum logic [3:0] {
        PH_START = 4'd0,
        PH_SKIP  = 4'd1,
        PH_SEP   = 4'd2,
        PH_LET2  = 4'd3,
        PH_DIG   = 4'd4,
        PH_SUF   = 4'd5,
        PH_TAIL  = 4'd6,
        PH_MDIG  = 4'd7,
        PH_MSUF  = 4'd8,
        PH_STOP  = 4'd9
    } phase_t;

    // Row slot a field writes into
    typedef enum logic [1:0] {
        TGT_NONE = 2'd0,
        TGT_REAL = 2'd1,
        TGT_IMAG = 2'd2,
        TGT_FREQ = 2'd3
    } target_t;

    typedef logic signed [5:0]  decade_t;
    typedef logic signed [31:0] mant_t;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LC_C  = 8'h63;
    localparam logic [7:0] CH_LC_D  = 8'h64;
    localparam logic [7:0] CH_LC_G  = 8'h67;

    // Mantissa offset: raw hex value minus 2^27
    localparam logic [31:0] MANT_OFFSET = 32'h0800_0000;

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if ((c >= 8'h41) && (c <= 8'h5A)) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    // Bit 4 flags a valid hex digit, bits 3:0 carry its value
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if ((c >= 8'h30) && (c <= 8'h39)) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if ((c >= 8'h41) && (c <= 8'h46)) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if ((c >= 8'h61) && (c <= 8'h66)) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

    // SI prefix to power of ten; anything else gives zero
    function automatic decade_t decade_of(input logic [7:0] c);
        decade_t d;
        case (c)
            8'h61: d = -6'sd18; // a
            8'h66: d = -6'sd15; // f
            8'h70: d = -6'sd12; // p
            8'h6E: d = -6'sd9;  // n
            8'h75: d = -6'sd6;  // u
            8'h6D: d = -6'sd3;  // m
            8'h6B: d = 6'sd3;   // k
            8'h4D: d = 6'sd6;   // M
            8'h47: d = 6'sd9;   // G
            default: d = 6'sd0;
        endcase
        return d;
    endfunction

endpackage

// File: src/impedance_packet_line_parser_top.sv
// ----------------------------------------------------------------------------
// Impedance packet line parser
// Byte-stream parser for 'P' packet lines; one result row per packet line.
// ----------------------------------------------------------------------------
// Takes one response byte per cycle on the s_ channel and, at the LF that
// closes a line starting with 'P', delivers one row of frequency, real and
// imaginary values, each as a 32-bit mantissa (hex value minus 2^27) and a
// power-of-ten decade from the SI suffix; fields that do not appear read as
// zero. CR bytes are dropped and other lines give no row. Each byte passes
// through an input register, one pass of the parse logic and the result
// register: a sustained rate of one byte per cycle while no row is stalled,
// with the row on the m_ ports once the parse logic has taken its LF. The
// result register is the only thing that stalls the stream: while a row
// waits for m_ready, the input register takes at most one further byte and
// holds it, and s_ready stays low from then until the row is taken.
// MAX_HEX_DIGITS (1 to 8) sets how many hex digits a field may carry before
// the next byte is read as its suffix.
module impedance_packet_line_parser_top #(
    parameter int MAX_HEX_DIGITS = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_data_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_freq_mantissa,
    output logic signed [5:0]   m_freq_decade,
    output logic signed [31:0]  m_real_mantissa,
    output logic signed [5:0]   m_real_decade,
    output logic signed [31:0]  m_imag_mantissa,
    output logic signed [5:0]   m_imag_decade
);

    localparam int CntW = $clog2(MAX_HEX_DIGITS + 1);

    // Input register
    logic                 in_vld_reg;
    logic [7:0]           in_byte_reg;

    // Parse state
    ipl_pkg::phase_t      phase_reg, phase_next;
    logic [31:0]          acc_reg, acc_next;
    logic [CntW-1:0]      cnt_reg, cnt_next;
    logic [7:0]           let1_reg, let1_next;
    ipl_pkg::target_t     tgt_reg, tgt_next;
    ipl_pkg::mant_t       freq_m_reg, freq_m_next;
    ipl_pkg::decade_t     freq_d_reg, freq_d_next;
    ipl_pkg::mant_t       real_m_reg, real_m_next;
    ipl_pkg::decade_t     real_d_reg, real_d_next;
    ipl_pkg::mant_t       imag_m_reg, imag_m_next;
    ipl_pkg::decade_t     imag_d_reg, imag_d_next;

    // Result register
    logic                 out_vld_reg;
    ipl_pkg::mant_t       out_freq_m_reg, out_real_m_reg, out_imag_m_reg;
    ipl_pkg::decade_t     out_freq_d_reg, out_real_d_reg, out_imag_d_reg;

    logic                 adv;
    logic                 proc;
    logic                 emit;
    logic                 commit;
    logic                 clr_row;
    ipl_pkg::decade_t     commit_dec;
    logic [4:0]           hv;
    logic [CntW-1:0]      cnt_inc;
    logic [7:0]           lc;
    ipl_pkg::mant_t       commit_mant;

    // The parse stage moves on whenever the result register is free or drains
    assign adv     = !out_vld_reg || m_ready;
    assign proc    = in_vld_reg && adv;
    assign s_ready = !in_vld_reg || adv;

    assign hv          = ipl_pkg::hex_val(in_byte_reg);
    assign cnt_inc     = cnt_reg + CntW'(1);
    assign lc          = ipl_pkg::to_lower(in_byte_reg);
    assign commit_mant = acc_reg - ipl_pkg::MANT_OFFSET;

    // Next parse state for the byte in the input register
    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        let1_next  = let1_reg;
        tgt_next   = tgt_reg;
        emit       = 1'b0;
        commit     = 1'b0;
        clr_row    = 1'b0;
        commit_dec = 6'sd0;

        if (in_byte_reg == ipl_pkg::CH_CR) begin
            // drop CR wherever it appears
        end else if (in_byte_reg == ipl_pkg::CH_LF) begin
            phase_next = ipl_pkg::PH_START;
            if ((phase_reg != ipl_pkg::PH_START) && (phase_reg != ipl_pkg::PH_SKIP)) begin
                emit = 1'b1;
                // a line that ends straight after the digits takes decade zero
                if (((phase_reg == ipl_pkg::PH_DIG) && (cnt_reg != '0)) ||
                    (phase_reg == ipl_pkg::PH_SUF)) begin
                    commit = 1'b1;
                end
            end
        end else begin
            case (phase_reg)
                ipl_pkg::PH_START: begin
                    if (in_byte_reg == ipl_pkg::CH_P) begin
                        clr_row    = 1'b1;
                        phase_next = ipl_pkg::PH_SEP;
                    end else begin
                        phase_next = ipl_pkg::PH_SKIP;
                    end
                end
                ipl_pkg::PH_SEP: begin
                    if ((in_byte_reg == ipl_pkg::CH_SEMI) ||
                        (in_byte_reg == ipl_pkg::CH_SPACE)) begin
                        phase_next = ipl_pkg::PH_SEP;
                    end else if (ipl_pkg::is_letter(in_byte_reg)) begin
                        let1_next  = lc;
                        phase_next = ipl_pkg::PH_LET2;
                    end else begin
                        phase_next = ipl_pkg::PH_STOP;
                    end
                end
                ipl_pkg::PH_LET2: begin
                    if (ipl_pkg::is_letter(in_byte_reg)) begin
                        if ((let1_reg == ipl_pkg::CH_LC_C) && (lc == ipl_pkg::CH_LC_C)) begin
                            tgt_next = ipl_pkg::TGT_REAL;
                        end else if ((let1_reg == ipl_pkg::CH_LC_C) &&
                                     (lc == ipl_pkg::CH_LC_D)) begin
                            tgt_next = ipl_pkg::TGT_IMAG;
                        end else if (((let1_reg == ipl_pkg::CH_LC_C) &&
                                      (lc == ipl_pkg::CH_LC_G)) ||
                                     ((let1_reg == ipl_pkg::CH_LC_D) &&
                                      (lc == ipl_pkg::CH_LC_C))) begin
                            tgt_next = ipl_pkg::TGT_FREQ;
                        end else begin
                            tgt_next = ipl_pkg::TGT_NONE;
                        end
                        acc_next   = '0;
                        cnt_next   = '0;
                        phase_next = ipl_pkg::PH_DIG;
                    end else begin
                        phase_next = ipl_pkg::PH_STOP;
                    end
                end
                ipl_pkg::PH_DIG: begin
                    if (hv[4]) begin
                        acc_next = {acc_reg[27:0], hv[3:0]};
                        cnt_next = cnt_inc;
                        if (cnt_inc == CntW'(MAX_HEX_DIGITS)) begin
                            phase_next = ipl_pkg::PH_SUF;
                        end
                    end else if (cnt_reg == '0) begin
                        phase_next = ipl_pkg::PH_STOP;
                    end else begin
                        commit     = 1'b1;
                        commit_dec = ipl_pkg::decade_of(in_byte_reg);
                        phase_next = ipl_pkg::PH_TAIL;
                    end
                end
                ipl_pkg::PH_SUF: begin
                    commit     = 1'b1;
                    commit_dec = ipl_pkg::decade_of(in_byte_reg);
                    phase_next = ipl_pkg::PH_TAIL;
                end
                ipl_pkg::PH_TAIL: begin
                    if (in_byte_reg == ipl_pkg::CH_SEMI) begin
                        phase_next = ipl_pkg::PH_SEP;
                    end else if (in_byte_reg == ipl_pkg::CH_COMMA) begin
                        cnt_next   = '0;
                        phase_next = ipl_pkg::PH_MDIG;
                    end
                end
                ipl_pkg::PH_MDIG: begin
                    // skip metadata digits, counting them only
                    if (hv[4]) begin
                        cnt_next = cnt_inc;
                        if (cnt_inc == CntW'(MAX_HEX_DIGITS)) begin
                            phase_next = ipl_pkg::PH_MSUF;
                        end
                    end else if (cnt_reg == '0) begin
                        phase_next = ipl_pkg::PH_STOP;
                    end else begin
                        phase_next = ipl_pkg::PH_TAIL;
                    end
                end
                ipl_pkg::PH_MSUF: begin
                    phase_next = ipl_pkg::PH_TAIL;
                end
                default: begin
                    // stopped: hold until LF
                end
            endcase
        end
    end

    // Row values after this byte: clear on 'P', overwrite on commit
    always_comb begin
        freq_m_next = freq_m_reg;
        freq_d_next = freq_d_reg;
        real_m_next = real_m_reg;
        real_d_next = real_d_reg;
        imag_m_next = imag_m_reg;
        imag_d_next = imag_d_reg;
        if (clr_row) begin
            freq_m_next = '0;
            freq_d_next = '0;
            real_m_next = '0;
            real_d_next = '0;
            imag_m_next = '0;
            imag_d_next = '0;
        end else if (commit) begin
            case (tgt_reg)
                ipl_pkg::TGT_REAL: begin
                    real_m_next = commit_mant;
                    real_d_next = commit_dec;
                end
                ipl_pkg::TGT_IMAG: begin
                    imag_m_next = commit_mant;
                    imag_d_next = commit_dec;
                end
                ipl_pkg::TGT_FREQ: begin
                    freq_m_next = commit_mant;
                    freq_d_next = commit_dec;
                end
                default: begin
                    // ignored field name
                end
            endcase
        end
    end

    // Input register: take a new item whenever the held one moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_byte_reg <= s_data_byte;
        end
    end

    // Parse state: advance only when the held byte is processed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= ipl_pkg::PH_START;
            acc_reg    <= '0;
            cnt_reg    <= '0;
            let1_reg   <= '0;
            tgt_reg    <= ipl_pkg::TGT_NONE;
            freq_m_reg <= '0;
            freq_d_reg <= '0;
            real_m_reg <= '0;
            real_d_reg <= '0;
            imag_m_reg <= '0;
            imag_d_reg <= '0;
        end else if (proc) begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            cnt_reg    <= cnt_next;
            let1_reg   <= let1_next;
            tgt_reg    <= tgt_next;
            freq_m_reg <= freq_m_next;
            freq_d_reg <= freq_d_next;
            real_m_reg <= real_m_next;
            real_d_reg <= real_d_next;
            imag_m_reg <= imag_m_next;
            imag_d_reg <= imag_d_next;
        end
    end

    // Result register: load a row at the LF of a packet line, hold while stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= in_vld_reg && emit;
        end
        if (proc && emit) begin
            out_freq_m_reg <= freq_m_next;
            out_freq_d_reg <= freq_d_next;
            out_real_m_reg <= real_m_next;
            out_real_d_reg <= real_d_next;
            out_imag_m_reg <= imag_m_next;
            out_imag_d_reg <= imag_d_next;
        end
    end

    assign m_valid         = out_vld_reg;
    assign m_freq_mantissa = out_freq_m_reg;
    assign m_freq_decade   = out_freq_d_reg;
    assign m_real_mantissa = out_real_m_reg;
    assign m_real_decade   = out_real_d_reg;
    assign m_imag_mantissa = out_imag_m_reg;
    assign m_imag_decade   = out_imag_d_reg;

endmodule

// File: src/ipl_checker.sv
// ----------------------------------------------------------------------------
// Impedance packet line parser checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module ipl_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic signed [31:0]  m_freq_mantissa,
    input logic signed [5:0]   m_freq_decade,
    input logic signed [31:0]  m_real_mantissa,
    input logic signed [5:0]   m_real_decade,
    input logic signed [31:0]  m_imag_mantissa,
    input logic signed [5:0]   m_imag_decade
);

    logic freq_ok, real_ok, imag_ok;

    // Decades are zero or an SI step from -18 to 9
    assign freq_ok = (m_freq_decade == -6'sd18) || (m_freq_decade == -6'sd15) ||
                     (m_freq_decade == -6'sd12) || (m_freq_decade == -6'sd9) ||
                     (m_freq_decade == -6'sd6)  || (m_freq_decade == -6'sd3) ||
                     (m_freq_decade == 6'sd0)   || (m_freq_decade == 6'sd3) ||
                     (m_freq_decade == 6'sd6)   || (m_freq_decade == 6'sd9);
    assign real_ok = (m_real_decade == -6'sd18) || (m_real_decade == -6'sd15) ||
                     (m_real_decade == -6'sd12) || (m_real_decade == -6'sd9) ||
                     (m_real_decade == -6'sd6)  || (m_real_decade == -6'sd3) ||
                     (m_real_decade == 6'sd0)   || (m_real_decade == 6'sd3) ||
                     (m_real_decade == 6'sd6)   || (m_real_decade == 6'sd9);
    assign imag_ok = (m_imag_decade == -6'sd18) || (m_imag_decade == -6'sd15) ||
                     (m_imag_decade == -6'sd12) || (m_imag_decade == -6'sd9) ||
                     (m_imag_decade == -6'sd6)  || (m_imag_decade == -6'sd3) ||
                     (m_imag_decade == 6'sd0)   || (m_imag_decade == 6'sd3) ||
                     (m_imag_decade == 6'sd6)   || (m_imag_decade == 6'sd9);

    a_decade_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (freq_ok && real_ok && imag_ok))
        else $error("row decade outside SI prefix set");

    a_no_row_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("row shown straight after reset");

    a_ready_while_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid && $past(!m_valid) && $past(aresetn)) |-> s_ready)
        else $error("input stalled while result side idle");

    a_row_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_freq_mantissa) &&
            $stable(m_real_mantissa) && $stable(m_imag_mantissa) &&
            $stable(m_freq_decade) && $stable(m_real_decade) &&
            $stable(m_imag_decade)))
        else $error("stalled row changed or dropped");

endmodule

bind impedance_packet_line_parser_top ipl_checker u_ipl_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_freq_mantissa (m_freq_mantissa),
    .m_freq_decade   (m_freq_decade),
    .m_real_mantissa (m_real_mantissa),
    .m_real_decade   (m_real_decade),
    .m_imag_mantissa (m_imag_mantissa),
    .m_imag_decade   (m_imag_decade)
);

// File: tb/ipl_row_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Impedance packet line parser row checker
// Tracks accepted bytes with its own line parser, queues the rows they should
// produce and compares every delivered row field by field in arrival order.
// ----------------------------------------------------------------------------
module ipl_row_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [7:0]         s_data_byte,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [31:0] m_freq_mantissa,
    input  logic signed [5:0]  m_freq_decade,
    input  logic signed [31:0] m_real_mantissa,
    input  logic signed [5:0]  m_real_decade,
    input  logic signed [31:0] m_imag_mantissa,
    input  logic signed [5:0]  m_imag_decade,
    output int                 fail_count,
    output int                 rows_pending
);

    localparam int DIGIT_LIMIT = 8;

    typedef struct packed {
        ipl_pkg::mant_t   mant;
        ipl_pkg::decade_t dec;
    } part_t;

    typedef struct packed {
        part_t freq;
        part_t res;
        part_t reac;
    } row_t;

    ipl_pkg::phase_t  ph;
    logic [31:0]      acc;
    int               ndig;
    logic [7:0]       lead;
    ipl_pkg::target_t slot;
    row_t             row;
    row_t             rows_due[$];

    initial begin
        fail_count   = 0;
        rows_pending = 0;
    end

    function automatic bit alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic [7:0] lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
    endfunction

    // -1 for anything that is not a hex digit
    function automatic int nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - 48;
        if (c >= "a" && c <= "f") return int'(c) - 87;
        if (c >= "A" && c <= "F") return int'(c) - 55;
        return -1;
    endfunction

    function automatic ipl_pkg::decade_t si_decade(input logic [7:0] c);
        case (c)
            "a":     return -6'sd18;
            "f":     return -6'sd15;
            "p":     return -6'sd12;
            "n":     return -6'sd9;
            "u":     return -6'sd6;
            "m":     return -6'sd3;
            "k":     return 6'sd3;
            "M":     return 6'sd6;
            "G":     return 6'sd9;
            default: return 6'sd0;
        endcase
    endfunction

    task automatic clear_parser();
        ph   = ipl_pkg::PH_START;
        acc  = '0;
        ndig = 0;
        lead = '0;
        slot = ipl_pkg::TGT_NONE;
        row  = '0;
    endtask

    task automatic commit(input ipl_pkg::decade_t d);
        part_t v;
        v.mant = acc - ipl_pkg::MANT_OFFSET;
        v.dec  = d;
        case (slot)
            ipl_pkg::TGT_REAL: row.res  = v;
            ipl_pkg::TGT_IMAG: row.reac = v;
            ipl_pkg::TGT_FREQ: row.freq = v;
            default: ;
        endcase
    endtask

    task automatic absorb_byte(input logic [7:0] c);
        ipl_pkg::phase_t was;
        int              h;
        logic [7:0]      b;
        if (c == ipl_pkg::CH_CR) return;
        if (c == ipl_pkg::CH_LF) begin
            was = ph;
            ph  = ipl_pkg::PH_START;
            if (was != ipl_pkg::PH_START && was != ipl_pkg::PH_SKIP) begin
                if ((was == ipl_pkg::PH_DIG && ndig != 0) || was == ipl_pkg::PH_SUF) begin
                    commit(6'sd0);
                end
                rows_due.push_back(row);
            end
            return;
        end
        h = nibble_of(c);
        case (ph)
            ipl_pkg::PH_START: begin
                if (c == ipl_pkg::CH_P) begin
                    row = '0;
                    ph  = ipl_pkg::PH_SEP;
                end else begin
                    ph = ipl_pkg::PH_SKIP;
                end
            end
            ipl_pkg::PH_SEP: begin
                if (c != ipl_pkg::CH_SEMI && c != ipl_pkg::CH_SPACE) begin
                    if (alpha(c)) begin
                        lead = lower(c);
                        ph   = ipl_pkg::PH_LET2;
                    end else begin
                        ph = ipl_pkg::PH_STOP;
                    end
                end
            end
            ipl_pkg::PH_LET2: begin
                if (alpha(c)) begin
                    b = lower(c);
                    if (lead == ipl_pkg::CH_LC_C && b == ipl_pkg::CH_LC_C) begin
                        slot = ipl_pkg::TGT_REAL;
                    end else if (lead == ipl_pkg::CH_LC_C && b == ipl_pkg::CH_LC_D) begin
                        slot = ipl_pkg::TGT_IMAG;
                    end else if ((lead == ipl_pkg::CH_LC_C && b == ipl_pkg::CH_LC_G) ||
                                 (lead == ipl_pkg::CH_LC_D && b == ipl_pkg::CH_LC_C)) begin
                        slot = ipl_pkg::TGT_FREQ;
                    end else begin
                        slot = ipl_pkg::TGT_NONE;
                    end
                    acc  = '0;
                    ndig = 0;
                    ph   = ipl_pkg::PH_DIG;
                end else begin
                    ph = ipl_pkg::PH_STOP;
                end
            end
            ipl_pkg::PH_DIG: begin
                if (h >= 0) begin
                    acc = {acc[27:0], 4'(h)};
                    ndig++;
                    if (ndig >= DIGIT_LIMIT) ph = ipl_pkg::PH_SUF;
                end else if (ndig == 0) begin
                    ph = ipl_pkg::PH_STOP;
                end else begin
                    commit(si_decade(c));
                    ph = ipl_pkg::PH_TAIL;
                end
            end
            ipl_pkg::PH_SUF: begin
                commit(si_decade(c));
                ph = ipl_pkg::PH_TAIL;
            end
            ipl_pkg::PH_TAIL: begin
                if (c == ipl_pkg::CH_SEMI) begin
                    ph = ipl_pkg::PH_SEP;
                end else if (c == ipl_pkg::CH_COMMA) begin
                    ndig = 0;
                    ph   = ipl_pkg::PH_MDIG;
                end
            end
            ipl_pkg::PH_MDIG: begin
                if (h >= 0) begin
                    ndig++;
                    if (ndig >= DIGIT_LIMIT) ph = ipl_pkg::PH_MSUF;
                end else if (ndig == 0) begin
                    ph = ipl_pkg::PH_STOP;
                end else begin
                    ph = ipl_pkg::PH_TAIL;
                end
            end
            ipl_pkg::PH_MSUF: ph = ipl_pkg::PH_TAIL;
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        row_t want;
        if (!aresetn) begin
            clear_parser();
            rows_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (rows_due.size() == 0) begin
                    $error("row delivered with none outstanding");
                    fail_count++;
                end else begin
                    want = rows_due.pop_front();
                    check_field("freq_mantissa", want.freq.mant, m_freq_mantissa);
                    check_field("freq_decade",   want.freq.dec,  m_freq_decade);
                    check_field("real_mantissa", want.res.mant,  m_real_mantissa);
                    check_field("real_decade",   want.res.dec,   m_real_decade);
                    check_field("imag_mantissa", want.reac.mant, m_imag_mantissa);
                    check_field("imag_decade",   want.reac.dec,  m_imag_decade);
                end
            end
            if (s_valid && s_ready) absorb_byte(s_data_byte);
        end
        rows_pending = rows_due.size();
    end

endmodule

// File: tb/impedance_packet_line_parser_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Impedance packet line parser testbench
// Feeds directed and random response lines through the parser with random
// gaps on both channels; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module impedance_packet_line_parser_top_tb;

    // Give up after this many cycles without a single handshake
    localparam int STALL_LIMIT = 2000;
    localparam int BYTE_TARGET = 650;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_data_byte;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_freq_mantissa;
    logic signed [5:0]  m_freq_decade;
    logic signed [31:0] m_real_mantissa;
    logic signed [5:0]  m_real_decade;
    logic signed [31:0] m_imag_mantissa;
    logic signed [5:0]  m_imag_decade;

    int         mismatches;
    int         rows_open;
    int         bytes_sent;
    int         idle_cycles;
    bit         calm;
    logic [7:0] line_buf[$];

    // SI prefixes plus 'i', which carries no exponent
    logic [7:0] si_pool[0:9] = '{"a", "f", "p", "n", "u", "m", "k", "M", "G", "i"};

    impedance_packet_line_parser_top DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_freq_mantissa (m_freq_mantissa),
        .m_freq_decade   (m_freq_decade),
        .m_real_mantissa (m_real_mantissa),
        .m_real_decade   (m_real_decade),
        .m_imag_mantissa (m_imag_mantissa),
        .m_imag_decade   (m_imag_decade)
    );

    ipl_row_checker u_row_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_freq_mantissa (m_freq_mantissa),
        .m_freq_decade   (m_freq_decade),
        .m_real_mantissa (m_real_mantissa),
        .m_real_decade   (m_real_decade),
        .m_imag_mantissa (m_imag_mantissa),
        .m_imag_decade   (m_imag_decade),
        .fail_count      (mismatches),
        .rows_pending    (rows_open)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Watchdog: count cycles in which neither channel moves an item
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // In calm stretches neither side idles at all
    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 9);
    endfunction

    // Randomly flip a lower-case letter to upper case
    function automatic logic [7:0] rand_case(input logic [7:0] c);
        return $urandom_range(0, 1) ? (c & 8'hDF) : c;
    endfunction

    function automatic logic [7:0] hex_char(input int v);
        return (v < 10) ? 8'(48 + v) : rand_case(8'(87 + v));
    endfunction

    // Present one item after a random gap and hold it until it is taken.
    // Enter and leave on a falling edge.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_buffer();
        foreach (line_buf[i]) send_byte(line_buf[i]);
        line_buf.delete();
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endtask

    // Hold the sender off until every predicted row has been delivered
    task automatic drain_rows();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (rows_open != 0) @(negedge aclk);
    endtask

    // Build one 'P' line of random fields; optionally damage one byte or
    // slip a CR in somewhere
    task automatic build_packet(input bit damage);
        int         nfield;
        int         pos;
        logic [7:0] name_a;
        logic [7:0] name_b;
        line_buf.push_back(ipl_pkg::CH_P);
        nfield = $urandom_range(0, 4);
        for (int f = 0; f < nfield; f++) begin
            if ($urandom_range(0, 2) == 0) begin
                line_buf.push_back($urandom_range(0, 1) ? ipl_pkg::CH_SEMI
                                                        : ipl_pkg::CH_SPACE);
            end
            case ($urandom_range(0, 5))
                0: begin name_a = "c"; name_b = "c"; end
                1: begin name_a = "c"; name_b = "d"; end
                2: begin name_a = "c"; name_b = "g"; end
                3: begin name_a = "d"; name_b = "c"; end
                default: begin
                    name_a = 8'(97 + $urandom_range(0, 25));
                    name_b = 8'(97 + $urandom_range(0, 25));
                end
            endcase
            line_buf.push_back(rand_case(name_a));
            line_buf.push_back(rand_case(name_b));
            repeat (($urandom_range(0, 3) == 0) ? 8 : $urandom_range(1, 8)) begin
                line_buf.push_back(hex_char($urandom_range(0, 15)));
            end
            // Sometimes end the line straight after the digits
            if (f == nfield - 1 && $urandom_range(0, 3) == 0) break;
            line_buf.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                          : si_pool[$urandom_range(0, 9)]);
            if ($urandom_range(0, 3) == 0) line_buf.push_back(8'($urandom_range(0, 255)));
            // Comma metadata: digits and a suffix byte to be skipped
            if ($urandom_range(0, 2) == 0) begin
                line_buf.push_back(ipl_pkg::CH_COMMA);
                repeat ($urandom_range(1, 8)) line_buf.push_back(hex_char($urandom_range(0, 15)));
                line_buf.push_back(8'($urandom_range(0, 255)));
            end
            if (f < nfield - 1) begin
                line_buf.push_back(ipl_pkg::CH_SEMI);
                if ($urandom_range(0, 3) == 0) line_buf.push_back(ipl_pkg::CH_SPACE);
            end
        end
        if (damage) begin
            pos = $urandom_range(0, line_buf.size() - 1);
            if ($urandom_range(0, 1)) line_buf[pos] = 8'($urandom_range(0, 255));
            else line_buf.insert(pos, ipl_pkg::CH_CR);
        end
        line_buf.push_back(ipl_pkg::CH_LF);
    endtask

    // Receiver: wait a random number of cycles, then take one row
    initial begin
        int gap;
        m_ready = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    initial begin
        int  line_count;
        int  sel;
        bit  paused;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data_byte = 8'h00;
        calm        = 1'b0;
        bytes_sent  = 0;
        idle_cycles = 0;
        line_count  = 0;
        paused      = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed lines. Empty line, and a non-packet line with a CR
        put_text("\nQ\r\n");
        // Non-packet line made of the extreme byte values
        line_buf.push_back(8'hFF);
        line_buf.push_back(8'h00);
        line_buf.push_back(ipl_pkg::CH_LF);
        // Packet with no fields at all: a row of zeros
        put_text("P\n");
        // Line ends straight after the digits
        put_text("Pcc0\n");
        // Mantissa extremes and a full eight digits, hex letter as suffix
        put_text("PcC88000000k;Cd87FFFFFFp;dc00000000f\n");
        // Space separator, metadata of both lengths, a repeated field
        put_text("P CG1a ;cd2u,1fM;cc3n,12345678x;cc4m\n");
        // Separator as suffix, both before and at the digit limit
        put_text("PdcF;\n");
        put_text("Pcc12345678;dc1G\n");
        // Comma straight after the digits is read as the suffix, so the line goes on
        put_text("Pcc1,;cd1\n");
        // Bad field start, bad second letter, no digits
        put_text("Pcc5p;1\n");
        put_text("Pcd5p;c;\n");
        put_text("Pcdx\n");
        // CR dropped in the middle of a field
        put_text("Pcc\r7\rk\n");
        send_buffer();
        drain_rows();

        // Random part: mostly well-formed packets, some damaged, some noise
        while (bytes_sent < BYTE_TARGET) begin
            if (line_count % 8 == 0) calm = ($urandom_range(0, 3) == 0);
            if (!paused && bytes_sent >= BYTE_TARGET / 2) begin
                drain_rows();
                paused = 1'b1;
            end
            sel = $urandom_range(0, 9);
            if (sel < 7) begin
                build_packet(1'b0);
            end else if (sel < 9) begin
                build_packet(1'b1);
            end else begin
                repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom_range(0, 255)));
                line_buf.push_back(ipl_pkg::CH_LF);
            end
            send_buffer();
            line_count++;
        end

        // Let the last rows come out, then allow the pipeline to settle
        drain_rows();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && rows_open == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
